### design/u2u_pkg.sv
// Shared types, character codes and UTF-8 helpers for the escape converter.
package u2u_pkg;

  localparam logic [7:0] CHAR_BSLASH = 8'h5c;
  localparam logic [7:0] CHAR_U      = 8'h75;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_SLASH = 2'd1,
    MODE_DIGIT = 2'd2
  } scan_mode_t;

  typedef struct packed {
    scan_mode_t  mode;
    logic [1:0]  digit_count;
    logic [15:0] code_point;
  } scan_state_t;

  typedef struct packed {
    logic [1:0]       n;
    logic [2:0][7:0]  bytes;
  } utf8_t;

  typedef struct packed {
    logic [1:0]       n;
    logic [2:0][7:0]  bytes;
    logic             bare;
    logic             stream_end;
  } result_t;

  localparam scan_state_t SCAN_RESET = '{mode: MODE_PLAIN, digit_count: 2'd0,
                                         code_point: 16'h0000};

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      v = 4'(c[3:0] + 4'd9);
    return v;
  endfunction

  // Encode a 16-bit code point; zero yields no byte.
  function automatic utf8_t utf8_enc(input logic [15:0] cp);
    utf8_t u;
    u = '0;
    if (cp == 16'h0000) begin
      u.n = 2'd0;
    end else if (cp < 16'h0080) begin
      u.n = 2'd1;
      u.bytes[0] = {1'b0, cp[6:0]};
    end else if (cp < 16'h0800) begin
      u.n = 2'd2;
      u.bytes[0] = {3'b110, cp[10:6]};
      u.bytes[1] = {2'b10, cp[5:0]};
    end else begin
      u.n = 2'd3;
      u.bytes[0] = {4'b1110, cp[15:12]};
      u.bytes[1] = {2'b10, cp[11:6]};
      u.bytes[2] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

endpackage

### design/u2u_decode.sv
// Next-state and result decode for one input byte of the escape scanner.
module u2u_decode (
  input  u2u_pkg::scan_state_t cur,
  input  logic [7:0]           char_in,
  input  logic                 stream_last,
  output u2u_pkg::scan_state_t nxt,
  output u2u_pkg::result_t     res
);
  import u2u_pkg::*;

  logic [15:0]     cp_acc;
  logic [15:0]     cp_pad;
  logic [1:0]      pre_n;
  logic [2:0][7:0] pre_bytes;
  scan_state_t     mid;
  utf8_t           u_full;
  utf8_t           u_pad;

  assign cp_acc = {cur.code_point[11:0], hex_value(char_in)};
  assign u_full = utf8_enc(cp_acc);

  always_comb begin
    mid       = cur;
    pre_n     = 2'd0;
    pre_bytes = '0;
    unique case (cur.mode)
      MODE_SLASH: begin
        if (char_in == CHAR_U) begin
          mid.mode        = MODE_DIGIT;
          mid.digit_count = 2'd0;
          mid.code_point  = 16'h0000;
        end else if (char_in == CHAR_BSLASH) begin
          pre_bytes[0] = CHAR_BSLASH;
          pre_n        = 2'd1;
        end else begin
          pre_bytes[0] = CHAR_BSLASH;
          pre_bytes[1] = char_in;
          pre_n        = 2'd2;
          mid.mode     = MODE_PLAIN;
        end
      end
      MODE_DIGIT: begin
        if (cur.digit_count == 2'd3) begin
          pre_bytes = u_full.bytes;
          pre_n     = u_full.n;
          mid       = SCAN_RESET;
        end else begin
          mid.code_point  = cp_acc;
          mid.digit_count = 2'(cur.digit_count + 2'd1);
        end
      end
      default: begin
        if (char_in == CHAR_BSLASH) begin
          mid.mode = MODE_SLASH;
        end else begin
          pre_bytes[0] = char_in;
          pre_n        = 2'd1;
          mid.mode     = MODE_PLAIN;
        end
      end
    endcase
  end

  // Pad the digits still missing from a partial escape with zeros.
  always_comb begin
    unique case (mid.digit_count)
      2'd1:    cp_pad = {mid.code_point[3:0], 12'h000};
      2'd2:    cp_pad = {mid.code_point[7:0], 8'h00};
      2'd3:    cp_pad = {mid.code_point[11:0], 4'h0};
      default: cp_pad = 16'h0000;
    endcase
  end

  assign u_pad = utf8_enc(cp_pad);

  always_comb begin
    res       = '0;
    res.bytes = pre_bytes;
    res.n     = pre_n;
    nxt       = mid;

    // Stream end: flush held backslash, partial escape or bare mark; reset.
    if (stream_last) begin
      if (mid.mode == MODE_SLASH) begin
        res.bytes[pre_n] = CHAR_BSLASH;
        res.n            = 2'(pre_n + 2'd1);
      end else if (mid.mode == MODE_DIGIT) begin
        res.bytes = u_pad.bytes;
        res.n     = u_pad.n;
      end
      if (res.n == 2'd0) begin
        res.n     = 2'd1;
        res.bare  = 1'b1;
        res.bytes = '0;
      end
      res.stream_end = 1'b1;
      nxt            = SCAN_RESET;
    end
  end

endmodule

### design/u2u_emit.sv
// Three-byte result buffer that drains one byte per output transfer.
module u2u_emit (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  u2u_pkg::result_t  res,
  output logic              free,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // byte_out
  output logic              m_tlast,
  output logic [1:0]        m_tuser    // [0] byte_valid, [1] stream_end
);
  import u2u_pkg::*;

  logic [2:0][7:0] bytes;
  logic [1:0]      left;
  logic            bare;
  logic            send_end;
  logic            take;

  assign m_tvalid = (left != 2'd0);
  assign take     = m_tvalid && m_tready;
  // Accept new work when empty or when the last byte leaves this cycle.
  assign free     = (left == 2'd0) || (left == 2'd1 && m_tready);
  assign m_tdata  = bytes[0];
  assign m_tlast  = (left == 2'd1);
  assign m_tuser  = {send_end && (left == 2'd1), !bare};

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= 2'd0;
    end else if (load) begin
      left <= res.n;
    end else if (take) begin
      left <= 2'(left - 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes    <= res.bytes;
      bare     <= res.bare;
      send_end <= res.stream_end;
    end else if (take) begin
      bytes <= {8'h00, bytes[2:1]};
    end
  end

endmodule

### design/unicode_escape_to_utf8_top.sv
// The first result byte is valid in the cycle after its input transfer.
// Throughput: one input byte per cycle while the output accepts and each
// byte yields at most one result; a byte with more (up to three) holds the
// input until the buffer, draining one byte per transfer, is at its last.
// Reset (rst, synchronous): scanner returns to plain copying, buffer empties.
module unicode_escape_to_utf8_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // char_in
  input  logic       s_tlast,   // stream_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // byte_out
  output logic       m_tlast,   // run_last
  output logic [1:0] m_tuser    // [0] byte_valid, [1] stream_end
);
  import u2u_pkg::*;

  scan_state_t scan;
  scan_state_t scan_next;
  result_t     res;
  logic        in_xfer;
  logic        free;

  assign s_tready = free;
  assign in_xfer  = s_tvalid && s_tready;

  u2u_decode dec (
    .cur         (scan),
    .char_in     (s_tdata),
    .stream_last (s_tlast),
    .nxt         (scan_next),
    .res         (res)
  );

  u2u_emit emit (
    .clk      (clk),
    .rst      (rst),
    .load     (in_xfer && (res.n != 2'd0)),
    .res      (res),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= SCAN_RESET;
    end else if (in_xfer) begin
      scan <= scan_next;
    end
  end

endmodule

### design/u2u_check.sv
// Port-level checks for the escape converter, bound to the top level.
module u2u_check (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic [1:0] m_tuser
);

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("stalled result changed");

  // A bare end mark carries no byte and closes both the run and the stream.
  a_bare: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast && m_tuser[1] && (m_tdata == 8'h00))
    else $error("bare end mark malformed");

  // Stream end only on the last result of a run.
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast)
    else $error("stream end without run end");

  // With no pending result the input side is open.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty buffer");

  // Reset empties the output.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind unicode_escape_to_utf8_top u2u_check chk (.*);
